// ===== design/rcb_pkg.sv =====
package rcb_pkg;

    localparam int CoordW = 16;
    localparam int EdgeW  = 18;  // right/bottom edge before the min, holds x + width

    // Request codes
    localparam logic CMD_CLIP = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_ORIGIN_X   = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y   = 2'd1;
    localparam logic [1:0] CFG_CLIP_COUNT = 2'd2;

    typedef struct packed {
        logic signed [CoordW-1:0] x1;
        logic signed [CoordW-1:0] y1;
        logic signed [CoordW-1:0] x2;
        logic signed [CoordW-1:0] y2;
    } box_t;

    typedef struct packed {
        logic signed [CoordW-1:0] x1;
        logic signed [CoordW-1:0] y1;
        logic signed [EdgeW-1:0]  x2;
        logic signed [EdgeW-1:0]  y2;
    } rect_t;

    // Rectangle travelling down the chain, with the one result held back
    // until it is known whether a later box hits too.
    typedef struct packed {
        logic  valid;
        rect_t rect;
        logic  pend_valid;
        box_t  pend;
    } token_t;

    typedef struct packed {
        logic valid;
        box_t box;
    } emit_t;

endpackage

// ===== design/rcb_cell.sv =====
module rcb_cell #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  logic [3:0]      box_index,
    input  rcb_pkg::box_t   box_in,
    input  logic [4:0]      clip_count,
    input  rcb_pkg::token_t tok_in,
    output rcb_pkg::token_t tok_out,
    output rcb_pkg::emit_t  emit
);

    rcb_pkg::box_t   box_reg;
    rcb_pkg::token_t tok_reg;
    rcb_pkg::token_t tok_next;

    logic                                 active;
    logic                                 hit;
    logic signed [rcb_pkg::CoordW-1:0]    a;
    logic signed [rcb_pkg::CoordW-1:0]    b;
    logic signed [rcb_pkg::EdgeW-1:0]     c;
    logic signed [rcb_pkg::EdgeW-1:0]     d;
    logic signed [rcb_pkg::EdgeW-1:0]     bx2;
    logic signed [rcb_pkg::EdgeW-1:0]     by2;

    assign active = int'(clip_count) > IDX;
    assign bx2    = rcb_pkg::EdgeW'(box_reg.x2);
    assign by2    = rcb_pkg::EdgeW'(box_reg.y2);

    always_comb
    begin
        a = (tok_in.rect.x1 > box_reg.x1) ? tok_in.rect.x1 : box_reg.x1;
        b = (tok_in.rect.y1 > box_reg.y1) ? tok_in.rect.y1 : box_reg.y1;
        c = (tok_in.rect.x2 < bx2) ? tok_in.rect.x2 : bx2;
        d = (tok_in.rect.y2 < by2) ? tok_in.rect.y2 : by2;
        hit = tok_in.valid && active
              && (rcb_pkg::EdgeW'(a) < c) && (rcb_pkg::EdgeW'(b) < d);

        tok_next = tok_in;
        if (hit)
        begin
            tok_next.pend_valid = 1'b1;
            tok_next.pend.x1    = a;
            tok_next.pend.y1    = b;
            tok_next.pend.x2    = c[rcb_pkg::CoordW-1:0];
            tok_next.pend.y2    = d[rcb_pkg::CoordW-1:0];
        end

        // A new hit releases the held result: it is not the last one.
        emit.valid = hit && tok_in.pend_valid;
        emit.box   = tok_in.pend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && (int'(box_index) == IDX))
        begin
            box_reg <= box_in;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== design/rect_clip_to_box_list_unit.sv =====
// Channel   Ports                                         Handshake
// -------   -------------------------------------------   ------------------------------
// request   cmd, rect_*, box_index, box_*                 taken when start && !busy
// result    out_x1, out_y1, out_x2, out_y2, last_box      one cycle, marked by result_valid
// config    cfg_index, cfg_data                           written when cfg_we is high
//
// A load request writes one clip box at its accepting edge; busy stays low.
// A clip request enters an entry register (origin added), then walks the row of
// MAX_CLIP_BOXES cells, one per cycle; busy stays high until it has left the row,
// and the next request is taken only once busy is low. The last
// result shows in the first cycle with busy low. Reset clears control and config;
// clip boxes are undefined until loaded. The receiver cannot stall.
module rect_clip_to_box_list_unit #(
    parameter int MAX_CLIP_BOXES = 16
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               start,
    output logic               busy,
    input  logic               cmd,
    input  logic signed [15:0] rect_x,
    input  logic signed [15:0] rect_y,
    input  logic [15:0]        rect_width,
    input  logic [15:0]        rect_height,
    input  logic [3:0]         box_index,
    input  logic signed [15:0] box_x1,
    input  logic signed [15:0] box_y1,
    input  logic signed [15:0] box_x2,
    input  logic signed [15:0] box_y2,

    output logic               result_valid,
    output logic signed [15:0] out_x1,
    output logic signed [15:0] out_y1,
    output logic signed [15:0] out_x2,
    output logic signed [15:0] out_y2,
    output logic               last_box,

    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    // Configuration registers
    logic signed [15:0] origin_x_reg;
    logic signed [15:0] origin_y_reg;
    logic [4:0]         clip_count_reg;

    // Chain links: link 0 is the entry register, link i+1 leaves cell i
    rcb_pkg::token_t tok [MAX_CLIP_BOXES+1];
    rcb_pkg::emit_t  emit [MAX_CLIP_BOXES];

    rcb_pkg::token_t entry_reg;
    rcb_pkg::token_t entry_next;

    logic            accept;
    logic            load;
    rcb_pkg::box_t   box_in;

    logic            result_valid_reg;
    logic            result_valid_next;
    logic            last_box_reg;
    logic            last_box_next;
    rcb_pkg::box_t   out_box_reg;
    rcb_pkg::box_t   out_box_next;

    logic            any_emit;
    rcb_pkg::box_t   emit_box;
    logic            chain_busy;

    assign accept = start && !busy;
    assign load   = accept && (cmd == rcb_pkg::CMD_LOAD);

    assign box_in.x1 = box_x1;
    assign box_in.y1 = box_y1;
    assign box_in.x2 = box_x2;
    assign box_in.y2 = box_y2;

    // Config writes: the origins take the whole data word, the clip count its low five bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            clip_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rcb_pkg::CFG_ORIGIN_X:   origin_x_reg   <= cfg_data;
                rcb_pkg::CFG_ORIGIN_Y:   origin_y_reg   <= cfg_data;
                rcb_pkg::CFG_CLIP_COUNT: clip_count_reg <= cfg_data[4:0];
                default:                 ;
            endcase
        end
    end

    // Entry: add the origin with 16-bit wrap, then form the far edges at
    // full width so a rectangle running past 16 bits still clips right.
    always_comb
    begin
        entry_next            = '0;
        entry_next.valid      = accept && (cmd == rcb_pkg::CMD_CLIP);
        entry_next.rect.x1    = rect_x + origin_x_reg;
        entry_next.rect.y1    = rect_y + origin_y_reg;
        entry_next.rect.x2    = rcb_pkg::EdgeW'(entry_next.rect.x1)
                                + $signed({2'b00, rect_width});
        entry_next.rect.y2    = rcb_pkg::EdgeW'(entry_next.rect.y1)
                                + $signed({2'b00, rect_height});
        entry_next.pend_valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign tok[0] = entry_reg;

    for (genvar i = 0; i < MAX_CLIP_BOXES; i++)
    begin : g_cell
        rcb_cell #(
            .IDX(i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load       (load),
            .box_index  (box_index),
            .box_in     (box_in),
            .clip_count (clip_count_reg),
            .tok_in     (tok[i]),
            .tok_out    (tok[i+1]),
            .emit       (emit[i])
        );
    end

    // Only one rectangle is in the row, so at most one cell emits per cycle.
    always_comb
    begin
        any_emit   = 1'b0;
        emit_box   = '0;
        chain_busy = 1'b0;
        for (int k = 0; k < MAX_CLIP_BOXES; k++)
        begin
            any_emit = any_emit | emit[k].valid;
            emit_box = emit_box | (emit[k].valid ? emit[k].box : '0);
        end
        for (int k = 0; k <= MAX_CLIP_BOXES; k++)
        begin
            chain_busy = chain_busy | tok[k].valid;
        end
    end

    assign busy = chain_busy;

    // Result select: a cell releasing an earlier hit, or the held hit
    // dropping out of the row end, which is the rectangle's last result.
    always_comb
    begin
        result_valid_next = 1'b0;
        last_box_next     = 1'b0;
        out_box_next      = emit_box;
        if (tok[MAX_CLIP_BOXES].valid && tok[MAX_CLIP_BOXES].pend_valid)
        begin
            result_valid_next = 1'b1;
            last_box_next     = 1'b1;
            out_box_next      = tok[MAX_CLIP_BOXES].pend;
        end
        else if (any_emit)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            last_box_reg     <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            last_box_reg     <= last_box_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_box_reg <= out_box_next;
    end

    assign result_valid = result_valid_reg;
    assign last_box     = last_box_reg;
    assign out_x1       = out_box_reg.x1;
    assign out_y1       = out_box_reg.y1;
    assign out_x2       = out_box_reg.x2;
    assign out_y2       = out_box_reg.y2;

endmodule
